[hdl/ldh_pkg.sv]
// shared types and constants for the ligand distance histogram
package ldh_pkg;

    localparam int REG_W     = 20;
    localparam int DIST_W    = 21;
    localparam int COUNT_W   = 24;
    localparam int FRAME_W   = 20;
    localparam int REP_W     = 4;
    localparam int SEL_W     = 5;
    localparam int BIN_COUNT = 30;
    localparam int REP_SLOTS = 16;
    localparam int ADDR_W    = 5;
    localparam int BASE_W    = 9;

    // shared unit widths
    localparam int OPND_W = 44;
    localparam int ROOT_W = 22;
    localparam int REM_W  = 26;
    localparam int ITER_W = 5;
    localparam int SQRT_STEPS = 22;
    localparam int DIV_STEPS  = 21;

    localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [FRAME_W-1:0] FRAME_MAX = '1;
    localparam logic [SEL_W-1:0]   NO_BIN    = 5'd30;
    localparam logic [SEL_W-1:0]   LAST_BIN  = 5'd29;

    // register indexes
    localparam logic [2:0] REG_BIN_START  = 3'd0;
    localparam logic [2:0] REG_BIN_WIDTH  = 3'd1;
    localparam logic [2:0] REG_AXIS_X     = 3'd2;
    localparam logic [2:0] REG_AXIS_Y1    = 3'd3;
    localparam logic [2:0] REG_AXIS_Y2    = 3'd4;
    localparam logic [2:0] REG_AXIS_Y3    = 3'd5;
    localparam logic [2:0] REG_SLAB_TOP   = 3'd6;
    localparam logic [2:0] REG_SLAB_BOT   = 3'd7;

    // commands and result kinds
    localparam logic CMD_ATOM  = 1'b0;
    localparam logic CMD_READ  = 1'b1;
    localparam logic KIND_BIN  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // shared unit modes
    localparam logic MODE_SQRT = 1'b0;
    localparam logic MODE_DIV  = 1'b1;

    typedef struct packed {
        logic start;
        logic mode;
    } t_unit_ctl;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_hist_req;

endpackage

[hdl/ldh_sqdiv.sv]
// shared iterative compare-subtract unit: integer square root and division
module ldh_sqdiv import ldh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_unit_ctl          i_ctl,
    input  logic [OPND_W-1:0]  i_operand,
    input  logic [REG_W-1:0]   i_divisor,
    output logic               o_done,
    output logic [ROOT_W-1:0]  o_result
);

    logic              r_busy;
    logic              r_done;
    logic              r_mode;
    logic [OPND_W-1:0] r_val;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_res;
    logic [REG_W-1:0]  r_div;
    logic [ITER_W-1:0] r_cnt;

    logic [REM_W-1:0]  shifted;
    logic [REM_W-1:0]  trial;
    logic              ge;
    logic [ITER_W-1:0] last_step;

    always_comb begin
        if (r_mode == MODE_SQRT) begin
            shifted   = {r_rem[REM_W-3:0], r_val[OPND_W-1 -: 2]};
            trial     = {2'b00, r_res, 2'b01};
            last_step = ITER_W'(SQRT_STEPS - 1);
        end else begin
            shifted   = {r_rem[REM_W-2:0], r_val[OPND_W-1]};
            trial     = {6'b0, r_div};
            last_step = ITER_W'(DIV_STEPS - 1);
        end
        ge = (shifted >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_mode <= i_ctl.mode;
                r_val  <= i_operand;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_res  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_rem <= ge ? (shifted - trial) : shifted;
                r_res <= {r_res[ROOT_W-2:0], ge};
                r_val <= (r_mode == MODE_SQRT) ? {r_val[OPND_W-3:0], 2'b00}
                                               : {r_val[OPND_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == last_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

[hdl/ldh_hist.sv]
// histogram count memory with clearing pass after reset
module ldh_hist import ldh_pkg::*; #(
    parameter int DEPTH = 480
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_hist_req                  i_req,
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    input  logic [COUNT_W-1:0]         i_wr_data,
    output logic [COUNT_W-1:0]         o_rd_data,
    output logic                       o_ready
);

    localparam int AW = $clog2(DEPTH);

    logic [COUNT_W-1:0] mem [DEPTH];
    logic [COUNT_W-1:0] r_rd_data;
    logic               r_clearing;
    logic [AW-1:0]      r_clr_addr;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [COUNT_W-1:0] wr_data;

    always_comb begin
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = i_req.wr_en;
            wr_addr = i_addr;
            wr_data = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clearing;

endmodule

[hdl/ligand_distance_histogram_core.sv]
// top level: sequencer, configuration registers and result register
// an atom that is not last runs the x distance and its square, then per axis point the y
//   distance, the sum and the 22-step square root on the shared unit, then the slab check
// a last atom then picks the bin (with the 21-step division where needed), reads the count
//   and gives the result; a read reads the count and gives the result; one item at a time;
//   a result waiting in the output register holds only the next result
// reset (synchronous, active low) restores registers and minima and clears the count memory
module ligand_distance_histogram_core import ldh_pkg::*; #(
    parameter int REPLICATES = 16,
    parameter int COORD_BITS = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_W-1:0]            paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_cmd,
    input  logic [REP_W-1:0]             i_replicate,
    input  logic [FRAME_W-1:0]           i_frame_index,
    input  logic signed [COORD_BITS-1:0] i_atom_x,
    input  logic signed [COORD_BITS-1:0] i_atom_y,
    input  logic signed [COORD_BITS-1:0] i_atom_z,
    input  logic                         i_last_atom,
    input  logic [SEL_W-1:0]             i_bin_select,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_result_kind,
    output logic [SEL_W-1:0]             o_bin_index,
    output logic                         o_by_height,
    output logic                         o_first_association,
    output logic [COUNT_W-1:0]           o_bin_count,
    output logic [FRAME_W-1:0]           o_association_frame
);

    localparam int HIST_DEPTH = REPLICATES * BIN_COUNT;
    localparam int HA_W       = $clog2(HIST_DEPTH);
    localparam int CW         = COORD_BITS;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DX    = 4'd1;
    localparam logic [3:0] S_SQX   = 4'd2;
    localparam logic [3:0] S_DY    = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_ROOT  = 4'd5;
    localparam logic [3:0] S_RWAIT = 4'd6;
    localparam logic [3:0] S_Z     = 4'd7;
    localparam logic [3:0] S_BIN   = 4'd8;
    localparam logic [3:0] S_DWAIT = 4'd9;
    localparam logic [3:0] S_RD    = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    // saturated magnitude of a coordinate difference
    function automatic logic [DIST_W-1:0] sat_mag(input logic signed [CW:0] d);
        logic [CW:0]  mag;
        logic [32:0]  mag33;
        mag   = (d < 0) ? CW'(0) - d : d;
        mag33 = 33'(mag);
        return (mag33 > 33'(DIST_MAX)) ? DIST_MAX : DIST_W'(mag33);
    endfunction

    // configuration registers
    logic [REG_W-1:0] r_bin_start, r_bin_width, r_axis_x;
    logic [REG_W-1:0] r_axis_y1, r_axis_y2, r_axis_y3, r_slab_top, r_slab_bot;

    logic       cfg_wr;
    logic [2:0] cfg_idx;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_start <= 20'd5120;
            r_bin_width <= 20'd5120;
            r_axis_x    <= 20'd62157;
            r_axis_y1   <= 20'd65536;
            r_axis_y2   <= 20'd60416;
            r_axis_y3   <= 20'd55296;
            r_slab_top  <= 20'd101100;
            r_slab_bot  <= 20'd25764;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_BIN_START: r_bin_start <= pwdata[REG_W-1:0];
                REG_BIN_WIDTH: r_bin_width <= pwdata[REG_W-1:0];
                REG_AXIS_X:    r_axis_x    <= pwdata[REG_W-1:0];
                REG_AXIS_Y1:   r_axis_y1   <= pwdata[REG_W-1:0];
                REG_AXIS_Y2:   r_axis_y2   <= pwdata[REG_W-1:0];
                REG_AXIS_Y3:   r_axis_y3   <= pwdata[REG_W-1:0];
                REG_SLAB_TOP:  r_slab_top  <= pwdata[REG_W-1:0];
                REG_SLAB_BOT:  r_slab_bot  <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_BIN_START: prdata = {12'b0, r_bin_start};
            REG_BIN_WIDTH: prdata = {12'b0, r_bin_width};
            REG_AXIS_X:    prdata = {12'b0, r_axis_x};
            REG_AXIS_Y1:   prdata = {12'b0, r_axis_y1};
            REG_AXIS_Y2:   prdata = {12'b0, r_axis_y2};
            REG_AXIS_Y3:   prdata = {12'b0, r_axis_y3};
            REG_SLAB_TOP:  prdata = {12'b0, r_slab_top};
            REG_SLAB_BOT:  prdata = {12'b0, r_slab_bot};
            default:       prdata = '0;
        endcase
    end

    // registers are 20 bits wide; seen as coordinates they are cut or
    // zero-extended to the coordinate width and taken as two's complement
    logic signed [CW-1:0] ax_c, ay_c, top_c, bot_c;
    logic [REG_W-1:0]     ay_sel;

    // sequencer and datapath registers
    logic [3:0]            r_state;
    logic                  r_cmd;
    logic [REP_W-1:0]      r_rep;
    logic [FRAME_W-1:0]    r_frame;
    logic signed [CW-1:0]  r_x, r_y, r_z;
    logic                  r_last;
    logic [1:0]            r_pt;
    logic [DIST_W-1:0]     r_dx, r_dy;
    logic [2*DIST_W-1:0]   r_sqx;
    logic [2*DIST_W-1:0]   sq_dy;
    logic [2*DIST_W:0]     r_sum;
    logic [DIST_W-1:0]     r_min_plane, r_min_height;
    logic                  r_outside;
    logic                  r_by_h;
    logic [SEL_W-1:0]      r_k;

    // result register
    logic                  r_out_valid;
    logic                  r_out_kind;
    logic [SEL_W-1:0]      r_out_bin;
    logic                  r_out_by_h;
    logic                  r_out_first;
    logic [COUNT_W-1:0]    r_out_count;
    logic [FRAME_W-1:0]    r_out_frame;

    logic [FRAME_W-1:0]    r_assoc [REP_SLOTS];

    always_comb begin
        case (r_pt)
            2'd0:    ay_sel = r_axis_y1;
            2'd1:    ay_sel = r_axis_y2;
            default: ay_sel = r_axis_y3;
        endcase
        ax_c  = CW'({12'b0, r_axis_x});
        ay_c  = CW'({12'b0, ay_sel});
        top_c = CW'({12'b0, r_slab_top});
        bot_c = CW'({12'b0, r_slab_bot});
    end

    // full-width square of the y distance
    assign sq_dy = r_dy * r_dy;

    // shared unit
    t_unit_ctl          unit_ctl;
    logic [OPND_W-1:0]  unit_opnd;
    logic               unit_done;
    logic [ROOT_W-1:0]  unit_res;

    // binning decision on the finished minima
    logic              by_h;
    logic              bin_short;
    logic [SEL_W-1:0]  bin_short_k;
    logic [DIST_W-1:0] num;

    always_comb begin
        by_h        = r_outside && (r_min_height > r_min_plane);
        bin_short   = 1'b1;
        bin_short_k = '0;
        num         = '0;
        if (by_h) begin
            if (r_min_height <= {1'b0, r_bin_width}) begin
                bin_short_k = '0;
            end else if (r_bin_width == '0) begin
                bin_short_k = NO_BIN;
            end else begin
                bin_short = 1'b0;
                num       = r_min_height - 1'b1;
            end
        end else begin
            if (r_min_plane <= {1'b0, r_bin_start}) begin
                bin_short_k = '0;
            end else if (r_bin_width == '0) begin
                bin_short_k = LAST_BIN;
            end else begin
                bin_short = 1'b0;
                num       = r_min_plane - {1'b0, r_bin_start} - 1'b1;
            end
        end
    end

    always_comb begin
        unit_ctl.start = 1'b0;
        unit_ctl.mode  = MODE_SQRT;
        unit_opnd      = {1'b0, r_sum};
        if (r_state == S_ROOT) begin
            unit_ctl.start = 1'b1;
        end else if (r_state == S_BIN && !bin_short) begin
            unit_ctl.start = 1'b1;
            unit_ctl.mode  = MODE_DIV;
            unit_opnd      = {num, (OPND_W - DIST_W)'(0)};
        end
    end

    ldh_sqdiv u_unit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (unit_ctl),
        .i_operand (unit_opnd),
        .i_divisor (r_bin_width),
        .o_done    (unit_done),
        .o_result  (unit_res)
    );

    // quotient to bin: height takes the floor directly, plane one more
    logic [SEL_W-1:0]  div_k;
    logic [ROOT_W-1:0] quot;
    assign quot = unit_res;
    always_comb begin
        if (r_by_h) begin
            div_k = (quot >= ROOT_W'(BIN_COUNT)) ? NO_BIN : SEL_W'(quot);
        end else begin
            div_k = (quot >= ROOT_W'(BIN_COUNT - 1)) ? LAST_BIN : SEL_W'(quot + 1'b1);
        end
    end

    logic [DIST_W-1:0] root_d;
    assign root_d = unit_res[ROOT_W-1] ? DIST_MAX : unit_res[DIST_W-1:0];

    // slab distance
    logic              outside_now;
    logic [DIST_W-1:0] dz_top, dz_bot, dz;
    always_comb begin
        outside_now = (r_z > top_c) || (r_z < bot_c);
        dz_top      = sat_mag((CW+1)'(r_z) - (CW+1)'(top_c));
        dz_bot      = sat_mag((CW+1)'(r_z) - (CW+1)'(bot_c));
        dz          = (dz_top < dz_bot) ? dz_top : dz_bot;
    end

    // count memory access
    logic               rep_ok;
    logic               counted;
    logic [BASE_W-1:0]  rep_base;
    logic [HA_W-1:0]    hist_addr;
    t_hist_req          hist_req;
    logic [COUNT_W-1:0] hist_rd, cnt_new;
    logic               hist_ready;
    logic               out_free;
    logic               finish;
    logic               first_hit;
    logic [FRAME_W:0]   frame_p1;
    logic [FRAME_W-1:0] frame_new;

    assign rep_ok   = (32'(r_rep) < REPLICATES);
    assign counted  = rep_ok && (r_k < SEL_W'(BIN_COUNT));
    assign rep_base = {r_rep, 5'b0} - {4'b0, r_rep, 1'b0};
    assign hist_addr = HA_W'(rep_base + {4'b0, r_k});
    assign cnt_new  = (hist_rd == COUNT_MAX) ? COUNT_MAX : hist_rd + 1'b1;
    assign out_free = !r_out_valid || !i_out_stall;
    assign finish   = (r_state == S_DONE) && out_free;
    assign first_hit = (r_cmd == CMD_ATOM) && counted && (r_k == '0)
                       && (r_assoc[r_rep] == '0);
    assign frame_p1  = {1'b0, r_frame} + 1'b1;
    assign frame_new = frame_p1[FRAME_W] ? FRAME_MAX : frame_p1[FRAME_W-1:0];

    assign hist_req.rd_en = (r_state == S_RD);
    assign hist_req.wr_en = finish && (r_cmd == CMD_ATOM) && counted;

    ldh_hist #(.DEPTH(HIST_DEPTH)) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (hist_req),
        .i_addr    (hist_addr),
        .i_wr_data (cnt_new),
        .o_rd_data (hist_rd),
        .o_ready   (hist_ready)
    );

    logic in_fire;
    assign o_in_stall = !(r_state == S_IDLE) || !hist_ready;
    assign in_fire    = i_in_valid && !o_in_stall;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_min_plane  <= DIST_MAX;
            r_min_height <= DIST_MAX;
            r_outside    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_cmd   <= i_cmd;
                        r_rep   <= i_replicate;
                        r_frame <= i_frame_index;
                        r_x     <= i_atom_x;
                        r_y     <= i_atom_y;
                        r_z     <= i_atom_z;
                        r_last  <= i_last_atom;
                        r_pt    <= 2'd0;
                        if (i_cmd == CMD_READ) begin
                            r_k     <= i_bin_select;
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_DX;
                        end
                    end
                end
                S_DX: begin
                    r_dx    <= sat_mag((CW+1)'(ax_c) - (CW+1)'(r_x));
                    r_state <= S_SQX;
                end
                S_SQX: begin
                    r_sqx   <= r_dx * r_dx;
                    r_state <= S_DY;
                end
                S_DY: begin
                    r_dy    <= sat_mag((CW+1)'(ay_c) - (CW+1)'(r_y));
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sum   <= {1'b0, r_sqx} + {1'b0, sq_dy};
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_state <= S_RWAIT;
                end
                S_RWAIT: begin
                    if (unit_done) begin
                        if (root_d < r_min_plane) begin
                            r_min_plane <= root_d;
                        end
                        if (r_pt == 2'd2) begin
                            r_state <= S_Z;
                        end else begin
                            r_pt    <= r_pt + 1'b1;
                            r_state <= S_DY;
                        end
                    end
                end
                S_Z: begin
                    if (outside_now) begin
                        r_outside <= 1'b1;
                        if (dz < r_min_height) begin
                            r_min_height <= dz;
                        end
                    end
                    r_state <= r_last ? S_BIN : S_IDLE;
                end
                S_BIN: begin
                    r_by_h <= by_h;
                    if (bin_short) begin
                        r_k     <= bin_short_k;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_DWAIT;
                    end
                end
                S_DWAIT: begin
                    if (unit_done) begin
                        r_k     <= div_k;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        if (r_cmd == CMD_ATOM) begin
                            r_min_plane  <= DIST_MAX;
                            r_min_height <= DIST_MAX;
                            r_outside    <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // association frames
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REP_SLOTS; i++) begin
                r_assoc[i] <= '0;
            end
        end else if (finish && first_hit) begin
            r_assoc[r_rep] <= frame_new;
        end
    end

    // result register; a finished result is held until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
            r_out_bin   <= r_k;
            if (r_cmd == CMD_READ) begin
                r_out_kind  <= KIND_READ;
                r_out_by_h  <= 1'b0;
                r_out_first <= 1'b0;
                r_out_count <= counted ? hist_rd : '0;
            end else begin
                r_out_kind  <= KIND_BIN;
                r_out_by_h  <= r_by_h;
                r_out_first <= first_hit;
                r_out_count <= counted ? cnt_new : '0;
            end
            if (!rep_ok) begin
                r_out_frame <= '0;
            end else if (first_hit) begin
                r_out_frame <= frame_new;
            end else begin
                r_out_frame <= r_assoc[r_rep];
            end
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_result_kind       = r_out_kind;
    assign o_bin_index         = r_out_bin;
    assign o_by_height         = r_out_by_h;
    assign o_first_association = r_out_first;
    assign o_bin_count         = r_out_count;
    assign o_association_frame = r_out_frame;

    // the shared unit only finishes while the sequencer waits for it
    a_unit_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        unit_done |-> (r_state == S_RWAIT || r_state == S_DWAIT))
        else $error("shared unit finished outside a wait state");

    // no item is taken during the clearing pass
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !hist_ready |-> o_in_stall)
        else $error("input taken while count memory is clearing");

    // a first association is a bin-zero binning outcome with a nonzero frame
    a_first_assoc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_first_association) |->
        (o_bin_index == '0 && o_result_kind == KIND_BIN && o_association_frame != '0))
        else $error("first association on a non bin-zero result");

    // an uncounted bin never reports a count
    a_uncounted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bin_index == NO_BIN) |-> (o_bin_count == '0))
        else $error("count reported for an uncounted bin");

endmodule
